[hdl/iff_pkg.sv]
`default_nettype none
package iff_pkg;
    localparam int MaxFieldDef = 64;
    localparam int MaxPrecDef  = 32;
    localparam int DigMax      = 24;
    localparam int BcdDigits   = 20;

    localparam logic [2:0] CmdSdec = 3'd0;
    localparam logic [2:0] CmdUdec = 3'd1;
    localparam logic [2:0] CmdOct  = 3'd2;
    localparam logic [2:0] CmdHex  = 3'd3;
    localparam logic [2:0] CmdUhex = 3'd4;
    localparam logic [2:0] CmdPtr  = 3'd5;

    localparam logic [1:0] LenInt   = 2'd0;
    localparam logic [1:0] LenShort = 2'd1;
    localparam logic [1:0] LenLong  = 2'd2;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChPlus  = 8'h2b;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [7:0] ChLx    = 8'h78;
    localparam logic [7:0] ChUx    = 8'h58;

    typedef enum logic [1:0] {
        t_base_dec = 2'd0,
        t_base_oct = 2'd1,
        t_base_hex = 2'd2
    } t_base;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic dig_done;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mag_zero;
        logic dig_full;
        logic div_busy;
        logic field_end;
    } t_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ChZero + {4'd0, d};
        end else if (upper) begin
            c = 8'h41 + {4'd0, d} - 8'd10;
        end else begin
            c = 8'h61 + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction
endpackage
`default_nettype wire

[hdl/iff_ctrl.sv]
`default_nettype none
module iff_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  iff_pkg::t_stat      i_stat,
    output iff_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_EMIT
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = i_start && (r_state == ST_IDLE);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.dig_done = (r_state == ST_PREP);
        o_cmd.emit     = (r_state == ST_EMIT);
        o_busy         = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: if (i_start) r_state <= ST_DIV;
                ST_DIV: begin
                    // wait out the decimal conversion; stop once the value is used up or the digit store is full
                    if (!i_stat.div_busy && (i_stat.mag_zero || i_stat.dig_full)) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: r_state <= ST_EMIT;
                ST_EMIT: if (i_stat.field_end) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/iff_dp.sv]
`default_nettype none
module iff_dp #(
    parameter int MAX_FIELD     = iff_pkg::MaxFieldDef,
    parameter int MAX_PRECISION = iff_pkg::MaxPrecDef
) (
    input  wire                 i_clk,
    input  iff_pkg::t_cmd       i_cmd,
    input  wire [2:0]           i_cmd_kind,
    input  wire [63:0]          i_value,
    input  wire [1:0]           i_length_mode,
    input  wire                 i_left_justify,
    input  wire                 i_force_sign,
    input  wire                 i_space_sign,
    input  wire                 i_zero_pad,
    input  wire                 i_alt_form,
    input  wire [6:0]           i_field_width,
    input  wire [5:0]           i_precision,
    input  wire                 i_precision_given,
    output iff_pkg::t_stat      o_stat,
    output logic [7:0]          o_out_char,
    output logic                o_char_valid,
    output logic                o_last
);
    localparam int WW = $clog2(MAX_FIELD + 1);
    localparam int PW = $clog2(MAX_PRECISION + 1);
    localparam int DW = $clog2(iff_pkg::DigMax + 1);
    localparam int BW = 4 * iff_pkg::BcdDigits;
    // total length bound: width or body
    localparam int LW = $clog2(MAX_FIELD + MAX_PRECISION + iff_pkg::DigMax + 8);

    logic [2:0]         r_kind;
    logic               r_left, r_zp, r_alt, r_pg, r_upper, r_neg, r_plus, r_space;
    logic [WW-1:0]      r_w;
    logic [PW-1:0]      r_p;
    iff_pkg::t_base     r_base;
    logic [63:0]        r_t;       // running quotient, or bits left to shift in
    logic               r_mag_nz;
    logic [3:0]         r_digs [iff_pkg::DigMax];
    logic [DW-1:0]      r_ndig;
    // decimal: binary to BCD, four bits per cycle
    logic [BW-1:0]      r_bcd;
    logic [3:0]         r_bit;
    logic               r_div_on;
    // emission bookkeeping
    logic [7:0]         r_sign;
    logic [LW-1:0]      r_pos, r_n;
    logic [LW-1:0]      r_e_pad, r_e_sign, r_e_pre, r_e_zeros, r_e_dig;

    logic [63:0]        n_mag;
    logic               n_neg;
    logic [64:0]        n_neg_mag;
    logic               n_dec;
    logic [BW-1:0]      n_bcd;
    logic [DW-1:0]      n_dec_nd;

    always_comb begin
        n_neg     = 1'b0;
        n_neg_mag = '0;
        if (i_cmd_kind == iff_pkg::CmdPtr) begin
            n_mag = i_value;
        end else begin
            case (i_length_mode)
                iff_pkg::LenInt:   n_mag = {32'd0, i_value[31:0]};
                iff_pkg::LenShort: n_mag = {48'd0, i_value[15:0]};
                default:           n_mag = i_value;
            endcase
            if (i_cmd_kind == iff_pkg::CmdSdec) begin
                case (i_length_mode)
                    iff_pkg::LenInt:   n_neg = i_value[31];
                    iff_pkg::LenShort: n_neg = i_value[15];
                    default:           n_neg = i_value[63];
                endcase
                if (n_neg) begin
                    n_neg_mag = 65'd0 - {1'b0, n_mag};
                    case (i_length_mode)
                        iff_pkg::LenInt:   n_mag = {32'd0, n_neg_mag[31:0]};
                        iff_pkg::LenShort: n_mag = {48'd0, n_neg_mag[15:0]};
                        default:           n_mag = n_neg_mag[63:0];
                    endcase
                end
            end
        end
        n_dec = !(i_cmd_kind == iff_pkg::CmdOct || i_cmd_kind == iff_pkg::CmdHex ||
                  i_cmd_kind == iff_pkg::CmdUhex || i_cmd_kind == iff_pkg::CmdPtr);
    end

    // add 3 to every BCD digit of 5 or more, then shift in the next bit
    always_comb begin
        n_bcd = r_bcd;
        for (int s = 0; s < 4; s++) begin
            for (int k = 0; k < iff_pkg::BcdDigits; k++) begin
                if (n_bcd[4*k +: 4] >= 4'd5) n_bcd[4*k +: 4] = n_bcd[4*k +: 4] + 4'd3;
            end
            n_bcd = {n_bcd[BW-2:0], r_t[63 - s]};
        end
        // decimal digit count: highest nonzero digit, at least one
        n_dec_nd = DW'(1);
        for (int k = 1; k < iff_pkg::BcdDigits; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) n_dec_nd = DW'(k + 1);
        end
    end

    wire w_dig_full = (r_ndig == DW'(iff_pkg::DigMax));
    assign o_stat.mag_zero  = (r_t == 64'd0) && (r_ndig != '0);
    assign o_stat.dig_full  = w_dig_full;
    assign o_stat.div_busy  = r_div_on;
    assign o_stat.field_end = (r_pos + 1'b1 == r_n) || (r_n == '0);

    // body sizing
    logic [LW-1:0] n_nd, n_zeros, n_body, n_pad;
    logic          n_empty;
    logic [1:0]    n_pre;
    logic          n_has_sign;
    always_comb begin
        n_empty = (r_kind != iff_pkg::CmdPtr) && r_pg && (r_p == '0) && !r_mag_nz;
        n_nd    = n_empty ? '0 : LW'(r_ndig);
        n_zeros = (LW'(r_p) > n_nd) ? LW'(r_p) - n_nd : '0;
        if (r_kind == iff_pkg::CmdOct && r_alt && n_zeros == '0 && !(n_nd != '0 && !r_mag_nz))
            n_zeros = LW'(1);
        n_pre = ((r_kind == iff_pkg::CmdPtr) ||
                 ((r_kind == iff_pkg::CmdHex || r_kind == iff_pkg::CmdUhex) && r_alt && r_mag_nz))
                ? 2'd2 : 2'd0;
        n_has_sign = (r_kind == iff_pkg::CmdSdec) && (r_neg || r_plus || r_space);
        n_body = LW'(n_has_sign) + LW'(n_pre) + n_zeros + n_nd;
        n_pad  = (LW'(r_w) > n_body) ? LW'(r_w) - n_body : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_cmd_kind;
            r_left   <= i_left_justify;
            r_zp     <= i_zero_pad;
            r_alt    <= i_alt_form;
            r_pg     <= i_precision_given;
            r_plus   <= i_force_sign;
            r_space  <= i_space_sign;
            r_upper  <= (i_cmd_kind == iff_pkg::CmdUhex);
            r_neg    <= n_neg;
            r_w      <= (32'(i_field_width) > 32'(MAX_FIELD)) ? WW'(MAX_FIELD)
                                                              : WW'(i_field_width);
            r_p      <= !i_precision_given ? '0 :
                        (32'(i_precision) > 32'(MAX_PRECISION)) ? PW'(MAX_PRECISION)
                                                                : PW'(i_precision);
            r_t      <= n_mag;
            r_mag_nz <= (n_mag != 64'd0);
            r_ndig   <= '0;
            r_bcd    <= '0;
            r_bit    <= '0;
            r_div_on <= n_dec;
            if (i_cmd_kind == iff_pkg::CmdOct) r_base <= iff_pkg::t_base_oct;
            else if (!n_dec) r_base <= iff_pkg::t_base_hex;
            else r_base <= iff_pkg::t_base_dec;
        end else if (i_cmd.div_step) begin
            if (r_div_on) begin
                // four value bits per cycle into the BCD register
                r_bcd <= n_bcd;
                r_t   <= r_t << 4;
                r_bit <= r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    r_div_on <= 1'b0;
                end
            end else if (!((r_t == 64'd0 && r_ndig != '0) || w_dig_full)) begin
                case (r_base)
                    iff_pkg::t_base_oct: begin
                        r_digs[r_ndig[$clog2(iff_pkg::DigMax)-1:0]] <= {1'b0, r_t[2:0]};
                        r_ndig <= r_ndig + 1'b1;
                        r_t    <= r_t >> 3;
                    end
                    iff_pkg::t_base_hex: begin
                        r_digs[r_ndig[$clog2(iff_pkg::DigMax)-1:0]] <= r_t[3:0];
                        r_ndig <= r_ndig + 1'b1;
                        r_t    <= r_t >> 4;
                    end
                    default: begin
                        // conversion done: store the decimal digits
                        for (int k = 0; k < iff_pkg::BcdDigits; k++) begin
                            r_digs[k] <= r_bcd[4*k +: 4];
                        end
                        r_ndig <= n_dec_nd;
                    end
                endcase
            end
        end else if (i_cmd.dig_done) begin
            r_sign  <= r_neg ? iff_pkg::ChMinus : r_plus ? iff_pkg::ChPlus : iff_pkg::ChSpace;
            r_n     <= n_body + n_pad;
            r_pos   <= '0;
            // segment end positions
            r_e_pad   <= (!r_left && !(r_zp && !r_pg)) ? n_pad : '0;
            r_e_sign  <= ((!r_left && !(r_zp && !r_pg)) ? n_pad : '0) + LW'(n_has_sign);
            r_e_pre   <= ((!r_left && !(r_zp && !r_pg)) ? n_pad : '0) + LW'(n_has_sign)
                         + LW'(n_pre);
            r_e_zeros <= ((!r_left) ? n_pad : '0) + LW'(n_has_sign) + LW'(n_pre) + n_zeros;
            r_e_dig   <= ((!r_left) ? n_pad : '0) + n_body;
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // character select at current position
    logic [LW-1:0] n_didx;
    always_comb begin
        n_didx       = r_e_dig - r_pos - 1'b1;
        o_char_valid = i_cmd.emit && (r_n != '0);
        o_last       = i_cmd.emit && o_stat.field_end;
        if (r_pos < r_e_pad)        o_out_char = iff_pkg::ChSpace;
        else if (r_pos < r_e_sign)  o_out_char = r_sign;
        else if (r_pos < r_e_pre)   o_out_char = (r_pos == r_e_pre - 1'b1) ?
                                        (r_upper ? iff_pkg::ChUx : iff_pkg::ChLx) : iff_pkg::ChZero;
        else if (r_pos < r_e_zeros) o_out_char = iff_pkg::ChZero;
        else if (r_pos < r_e_dig)
            o_out_char = iff_pkg::digit_char(r_digs[n_didx[$clog2(iff_pkg::DigMax)-1:0]], r_upper);
        else                        o_out_char = iff_pkg::ChSpace;
        if (r_n == '0) o_out_char = 8'd0;
    end
endmodule
`default_nettype wire

[hdl/integer_field_formatter_top.sv]
`default_nettype none
// Channel  | Ports                                   | Handshake
// input    | i_cmd .. i_precision_given              | start high while busy low
// result   | o_out_char, o_char_valid, o_last        | o_strobe, one cycle, no stall
//
// Per transaction, from the accept edge: octal or hex stores one digit per cycle
// until the value is used up or the digit store is full; decimal shifts the value
// into BCD four bits a cycle, then does one digit store; then come one sizing step
// and one output character per cycle (up to the larger of width and body, or an
// invalid null if empty). busy drops in the cycle after the last character.
// Reset (i_rst_n low, synchronous) returns the controller to idle.
// The receiver cannot stall: each character is shown for one cycle only.
module integer_field_formatter_top #(
    parameter int MAX_FIELD     = iff_pkg::MaxFieldDef,
    parameter int MAX_PRECISION = iff_pkg::MaxPrecDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [2:0]   i_cmd,
    input  wire [63:0]  i_value,
    input  wire [1:0]   i_length_mode,
    input  wire         i_left_justify,
    input  wire         i_force_sign,
    input  wire         i_space_sign,
    input  wire         i_zero_pad,
    input  wire         i_alt_form,
    input  wire [6:0]   i_field_width,
    input  wire [5:0]   i_precision,
    input  wire         i_precision_given,
    output logic        o_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_last
);
    iff_pkg::t_cmd  w_cmd;
    iff_pkg::t_stat w_stat;

    iff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    iff_dp #(
        .MAX_FIELD     (MAX_FIELD),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_dp (
        .i_clk             (i_clk),
        .i_cmd             (w_cmd),
        .i_cmd_kind        (i_cmd),
        .i_value           (i_value),
        .i_length_mode     (i_length_mode),
        .i_left_justify    (i_left_justify),
        .i_force_sign      (i_force_sign),
        .i_space_sign      (i_space_sign),
        .i_zero_pad        (i_zero_pad),
        .i_alt_form        (i_alt_form),
        .i_field_width     (i_field_width),
        .i_precision       (i_precision),
        .i_precision_given (i_precision_given),
        .o_stat            (w_stat),
        .o_out_char        (o_out_char),
        .o_char_valid      (o_char_valid),
        .o_last            (o_last)
    );

    // one result per emit cycle
    assign o_strobe = w_cmd.emit;
endmodule
`default_nettype wire

[test/iff_checker.sv]
`default_nettype none
module iff_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    input  wire        busy,
    input  wire [2:0]  i_cmd,
    input  wire [63:0] i_value,
    input  wire [1:0]  i_length_mode,
    input  wire        i_left_justify,
    input  wire        i_force_sign,
    input  wire        i_space_sign,
    input  wire        i_zero_pad,
    input  wire        i_alt_form,
    input  wire [6:0]  i_field_width,
    input  wire [5:0]  i_precision,
    input  wire        i_precision_given,
    input  wire        o_strobe,
    input  wire [7:0]  o_out_char,
    input  wire        o_char_valid,
    input  wire        o_last,
    output int         o_fail_count,
    output int         o_pending
);
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } t_char;

    t_char pending_chars[$];
    int    mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_chars.size();

    function automatic logic [7:0] to_ascii(input logic [3:0] d, input logic upper);
        if (d < 4'd10) return 8'h30 + {4'd0, d};
        return (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
    endfunction

    // Build the character stream of one conversion and queue it.
    task automatic format_field();
        logic [2:0]  kind;
        logic [63:0] mag;
        logic [63:0] sbit;
        logic [7:0]  digs[24];
        logic [7:0]  line[$];
        logic [7:0]  sign;
        logic [4:0]  radix;
        logic        neg, upper, pg, zfill;
        int          w, p, ndig, zeros, pre, body, pad;
        kind  = i_cmd;
        if (kind > iff_pkg::CmdPtr) kind = iff_pkg::CmdUdec;
        radix = 10; neg = 0; upper = 0; sign = 0; pre = 0; ndig = 0;
        pg = i_precision_given;
        w  = (i_field_width > 64) ? 64 : i_field_width;
        p  = (i_precision > 32) ? 32 : i_precision;
        if (!pg) p = 0;
        if (kind == iff_pkg::CmdPtr) begin
            mag = i_value; radix = 16;
        end else begin
            case (i_length_mode)
                iff_pkg::LenInt:   begin mag = i_value & 64'hFFFF_FFFF; sbit = 64'h8000_0000; end
                iff_pkg::LenShort: begin mag = i_value & 64'hFFFF; sbit = 64'h8000; end
                default:  begin mag = i_value; sbit = 64'h8000_0000_0000_0000; end
            endcase
            if (kind == iff_pkg::CmdSdec && (mag & sbit) != 0) begin
                neg = 1;
                mag = ((sbit << 1) - mag) & ((sbit << 1) - 1);
                if (sbit[63]) mag = -i_value;
                if (mag == 0) mag = sbit;
            end else if (kind == iff_pkg::CmdOct) begin
                radix = 8;
            end else if (kind == iff_pkg::CmdHex || kind == iff_pkg::CmdUhex) begin
                radix = 16; upper = (kind == iff_pkg::CmdUhex);
            end
        end
        begin
            logic [63:0] t;
            t = mag;
            do begin
                digs[ndig] = to_ascii(4'(t % radix), upper);
                ndig++;
                t = t / radix;
            end while (t != 0 && ndig < 24);
        end
        if (kind != iff_pkg::CmdPtr && pg && p == 0 && mag == 0) ndig = 0;
        zeros = (p > ndig) ? p - ndig : 0;
        if (kind == iff_pkg::CmdSdec) begin
            if (neg) sign = iff_pkg::ChMinus;
            else if (i_force_sign) sign = iff_pkg::ChPlus;
            else if (i_space_sign) sign = iff_pkg::ChSpace;
        end
        if (kind == iff_pkg::CmdOct && i_alt_form && zeros == 0 && !(ndig > 0 && mag == 0))
            zeros = 1;
        if (kind == iff_pkg::CmdPtr ||
            ((kind == iff_pkg::CmdHex || kind == iff_pkg::CmdUhex) && i_alt_form && mag != 0))
            pre = 2;
        body  = (sign != 0) + pre + zeros + ndig;
        pad   = (w > body) ? w - body : 0;
        zfill = i_zero_pad && !pg && !i_left_justify;
        if (!i_left_justify && !zfill) repeat (pad) line.push_back(iff_pkg::ChSpace);
        if (sign != 0) line.push_back(sign);
        if (pre != 0) begin
            line.push_back(iff_pkg::ChZero);
            line.push_back(kind == iff_pkg::CmdUhex ? iff_pkg::ChUx : iff_pkg::ChLx);
        end
        if (zfill) repeat (pad) line.push_back(iff_pkg::ChZero);
        repeat (zeros) line.push_back(iff_pkg::ChZero);
        for (int i = ndig; i > 0; i--) line.push_back(digs[i - 1]);
        if (i_left_justify) repeat (pad) line.push_back(iff_pkg::ChSpace);
        if (line.size() == 0) begin
            pending_chars.push_back('{ch: 8'd0, valid: 1'b0, last: 1'b1});
        end else begin
            foreach (line[i])
                pending_chars.push_back('{ch: line[i], valid: 1'b1,
                                         last: (i == line.size() - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mismatches <= 0;
        end else begin
            if (o_strobe) begin
                if (pending_chars.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected char %h valid %b last %b",
                                 o_out_char, o_char_valid, o_last);
                    mismatches <= mismatches + 1;
                end else begin
                    t_char exp_c;
                    exp_c = pending_chars.pop_front();
                    if (exp_c.ch !== o_out_char || exp_c.valid !== o_char_valid
                        || exp_c.last !== o_last) begin
                        if (mismatches < 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     exp_c.ch, exp_c.valid, exp_c.last,
                                     o_out_char, o_char_valid, o_last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy) format_field();
        end
    end
endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  i_cmd = 0;
    logic [63:0] i_value = 0;
    logic [1:0]  i_length_mode = 0;
    logic        i_left_justify = 0;
    logic        i_force_sign = 0;
    logic        i_space_sign = 0;
    logic        i_zero_pad = 0;
    logic        i_alt_form = 0;
    logic [6:0]  i_field_width = 0;
    logic [5:0]  i_precision = 0;
    logic        i_precision_given = 0;
    logic        o_strobe;
    logic [7:0]  o_out_char;
    logic        o_char_valid;
    logic        o_last;
    int          fail_count;
    int          pending;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    integer_field_formatter_top dut (.*);
    iff_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    // Random 64-bit value that often sits near a sign boundary or zero.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return {$urandom, $urandom};
            2: return {32'hFFFF_FFFF, $urandom} ^ (64'd1 << $urandom_range(0, 63));
            3: return 64'd1 << $urandom_range(0, 63);
            4: return 64'($urandom_range(0, 1000));
            default: return -{32'd0, $urandom_range(0, 1000)};
        endcase
    endfunction

    // Hold one transaction on the ports until it is accepted.
    task automatic send(input logic [2:0] cmd, input logic [63:0] val, input logic [1:0] len,
                        input logic [4:0] flags, input logic [6:0] w,
                        input logic [5:0] p, input logic pg);
        i_cmd             <= cmd;
        i_value           <= val;
        i_length_mode     <= len;
        {i_left_justify, i_force_sign, i_space_sign, i_zero_pad, i_alt_form} <= flags;
        i_field_width     <= w;
        i_precision       <= p;
        i_precision_given <= pg;
        start             <= 1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic random_item(input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 37) begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        // keep widths mostly small so the run stays short
        send(3'($urandom_range(0, 7)), pick_value(), 2'($urandom_range(0, 3)), 5'($urandom),
             ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24)),
             ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12)),
             1'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every kind, extremes, empty field, saturation
        send(iff_pkg::CmdSdec, 64'h8000_0000, iff_pkg::LenInt, 5'b00000, 7'd0, 6'd0, 1'b0);
        send(iff_pkg::CmdSdec, 64'h8000, iff_pkg::LenShort, 5'b01000, 7'd10, 6'd0, 1'b0);
        send(iff_pkg::CmdSdec, 64'h8000_0000_0000_0000, iff_pkg::LenLong, 5'b00000,
             7'd0, 6'd0, 1'b0);
        send(iff_pkg::CmdSdec, 64'd42, iff_pkg::LenInt, 5'b01010, 7'd8, 6'd0, 1'b0);
        send(iff_pkg::CmdSdec, 64'd42, iff_pkg::LenInt, 5'b00110, 7'd8, 6'd0, 1'b0);
        send(iff_pkg::CmdSdec, 64'd0, iff_pkg::LenInt, 5'b00000, 7'd0, 6'd0, 1'b1);
        send(iff_pkg::CmdUdec, 64'd0, iff_pkg::LenInt, 5'b00000, 7'd0, 6'd0, 1'b1);
        send(iff_pkg::CmdOct, 64'd0, iff_pkg::LenInt, 5'b00001, 7'd0, 6'd0, 1'b1);
        send(iff_pkg::CmdOct, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 5'b00001, 7'd0, 6'd0, 1'b0);
        send(iff_pkg::CmdHex, 64'd0, iff_pkg::LenInt, 5'b00001, 7'd5, 6'd0, 1'b1);
        send(iff_pkg::CmdHex, 64'hDEAD_BEEF, iff_pkg::LenInt, 5'b10001, 7'd20, 6'd0, 1'b0);
        send(iff_pkg::CmdUhex, 64'hDEAD_BEEF, iff_pkg::LenInt, 5'b00011, 7'd20, 6'd0, 1'b0);
        send(iff_pkg::CmdUhex, 64'hABCD, iff_pkg::LenShort, 5'b00011, 7'd12, 6'd6, 1'b1);
        send(iff_pkg::CmdPtr, 64'd0, iff_pkg::LenShort, 5'b00000, 7'd0, 6'd0, 1'b1);
        send(iff_pkg::CmdPtr, 64'hFFFF_FFFF_FFFF_FFFF, iff_pkg::LenInt, 5'b10000,
             7'd127, 6'd63, 1'b1);
        send(3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 5'b11111, 7'd127, 6'd63, 1'b0);
        send(3'd7, 64'd12345, iff_pkg::LenShort, 5'b01110, 7'd64, 6'd33, 1'b1);
        send(iff_pkg::CmdUdec, 64'hFFFF_FFFF_FFFF_FFFF, iff_pkg::LenLong, 5'b00000,
             7'd0, 6'd32, 1'b1);
        send(iff_pkg::CmdOct, 64'o777, iff_pkg::LenInt, 5'b00001, 7'd0, 6'd5, 1'b1);

        // no-idle stretch, then random idling
        repeat (25) random_item(0);
        start <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
        repeat (66) random_item(1);
        start <= 0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hdl/iff_pkg.sv
hdl/iff_ctrl.sv
hdl/iff_dp.sv
hdl/integer_field_formatter_top.sv
test/iff_checker.sv
test/testbench.sv
